// ----- design/ffd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the feedback frame deframer: status codes, register
// indexes and beat layouts. No dependencies.
package ffd_pkg;

	localparam int unsigned POS_W    = 5;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// status codes, in check order
	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_HEADER   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_COMMAND  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_CHECKSUM = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 1'd1;

	// byte positions inside a frame
	localparam logic [POS_W-1:0] POS_HEADER     = 5'd0;
	localparam logic [POS_W-1:0] POS_COMMAND    = 5'd1;
	localparam logic [POS_W-1:0] POS_LEFT       = 5'd2;
	localparam logic [POS_W-1:0] POS_RIGHT      = 5'd6;
	localparam logic [POS_W-1:0] POS_BATTERY    = 5'd10;
	localparam logic [POS_W-1:0] POS_FAULT      = 5'd14;

	// result beat layout, highest bit first
	localparam int unsigned RES_BITS = STATUS_W + 3 * WORD_W + BYTE_W;
	localparam int unsigned RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [BYTE_W-1:0]   fault_value;
		logic [WORD_W-1:0]   battery_bits;
		logic [WORD_W-1:0]   right_distance_bits;
		logic [WORD_W-1:0]   left_distance_bits;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ----- design/feedback_frame_deframer_top.sv -----
`timescale 1ns / 1ps
// Feedback frame deframer: byte stream in, one decoded result beat per frame.
// Depends on ffd_pkg for status codes, register indexes and the result layout.
//
// Usage:
//   Input channel (s_*): one frame byte per beat in s_tdata, with s_tuser set on
//   byte 0 of a frame. A start beat drops any partial frame. Beats outside a
//   frame are dropped silently.
//   Output channel (m_*): one beat per complete frame of FRAME_BYTES bytes,
//   sent when the checksum byte is taken. Status reports the first failing
//   check (header, command, checksum); on failure all data fields are zero.
//   Config channel (cfg_*): always ready; write header/command compare values
//   only while the block is idle.
// Timing: one byte per cycle sustained while s_tready is high. The result appears in the
//   cycle after the checksum beat is accepted, held in the single result register.
// Stall: the result register parts the two sides, so payload beats keep flowing
//   while a result waits; only a beat arriving while the open frame sits at its
//   checksum position is held back until the earlier result is taken
//   (s_tready = !m_tvalid || m_tready || not at the checksum position).
// Reset: clears the frame tracker, the result valid and both compare values;
//   the block is ready in the first cycle after reset.
module feedback_frame_deframer_top #(
	parameter int unsigned FRAME_BYTES = 25
) (
	input  logic clk,
	input  logic arst_n,

	// input bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start

	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [33:2] left_distance_bits, [65:34] right_distance_bits,
	// [97:66] battery_bits, [105:98] fault_value, [111:106] zero
	output logic [ffd_pkg::RES_TDATA_W-1:0] m_tdata,

	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffd_pkg::BYTE_W-1:0]     cfg_data
);

	localparam logic [ffd_pkg::POS_W-1:0] LAST_POS = ffd_pkg::POS_W'(FRAME_BYTES - 1);

	// configuration
	logic [7:0] hdr_q;
	logic [7:0] cmd_q;

	// frame tracker
	logic [ffd_pkg::POS_W-1:0]    pos_q;
	logic                         in_frame_q;
	logic [7:0]                   sum_q;
	logic [ffd_pkg::STATUS_W-1:0] fail_q;
	logic [31:0]                  left_q;
	logic [31:0]                  right_q;
	logic [31:0]                  batt_q;
	logic [7:0]                   fault_q;

	// result register
	logic                 res_valid_q;
	ffd_pkg::result_t     res_q;

	// frame state as seen by this beat (start resets it first)
	logic [ffd_pkg::POS_W-1:0]    base_pos;
	logic                         base_in_frame;
	logic [7:0]                   base_sum;
	logic [ffd_pkg::STATUS_W-1:0] base_fail;
	logic [31:0]                  base_left;
	logic [31:0]                  base_right;
	logic [31:0]                  base_batt;
	logic [7:0]                   base_fault;

	logic [ffd_pkg::STATUS_W-1:0] nxt_fail;
	logic [31:0]                  nxt_left;
	logic [31:0]                  nxt_right;
	logic [31:0]                  nxt_batt;
	logic [7:0]                   nxt_fault;

	logic                 in_acc;
	logic                 is_last;
	logic [1:0]           lane;
	logic [ffd_pkg::POS_W-1:0] lane_off;
	ffd_pkg::result_t     res_d;

	assign cfg_ready = 1'b1;
	// Hold input only when the next beat could end a frame while a result waits.
	assign s_tready  = !res_valid_q || m_tready || !(in_frame_q && pos_q == LAST_POS);
	assign in_acc    = s_tvalid && s_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			cmd_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffd_pkg::REG_HEADER:  hdr_q <= cfg_data;
				ffd_pkg::REG_COMMAND: cmd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Start of frame: open a fresh frame before looking at this byte.
	always_comb begin
		if (s_tuser) begin
			base_pos      = '0;
			base_in_frame = 1'b1;
			base_sum      = '0;
			base_fail     = ffd_pkg::ST_OK;
			base_left     = '0;
			base_right    = '0;
			base_batt     = '0;
			base_fault    = '0;
		end else begin
			base_pos      = pos_q;
			base_in_frame = in_frame_q;
			base_sum      = sum_q;
			base_fail     = fail_q;
			base_left     = left_q;
			base_right    = right_q;
			base_batt     = batt_q;
			base_fault    = fault_q;
		end
	end

	// The three words are 4 bytes apart, so the lane is the offset from the
	// left word's first byte, modulo 4.
	assign lane_off = base_pos - ffd_pkg::POS_LEFT;
	assign lane     = lane_off[1:0];
	assign is_last  = (base_pos == LAST_POS);

	// Per-byte checks and field capture.
	always_comb begin
		nxt_fail  = base_fail;
		nxt_left  = base_left;
		nxt_right = base_right;
		nxt_batt  = base_batt;
		nxt_fault = base_fault;
		if (is_last) begin
			if (s_tdata != base_sum && base_fail == ffd_pkg::ST_OK)
				nxt_fail = ffd_pkg::ST_BAD_CHECKSUM;
		end else if (base_pos == ffd_pkg::POS_HEADER && s_tdata != hdr_q) begin
			if (base_fail == ffd_pkg::ST_OK)
				nxt_fail = ffd_pkg::ST_BAD_HEADER;
		end else if (base_pos == ffd_pkg::POS_COMMAND && s_tdata != cmd_q) begin
			if (base_fail == ffd_pkg::ST_OK)
				nxt_fail = ffd_pkg::ST_BAD_COMMAND;
		end else if (base_pos >= ffd_pkg::POS_LEFT && base_pos < ffd_pkg::POS_RIGHT) begin
			nxt_left[{lane, 3'b000} +: 8] = s_tdata;
		end else if (base_pos >= ffd_pkg::POS_RIGHT && base_pos < ffd_pkg::POS_BATTERY) begin
			nxt_right[{lane, 3'b000} +: 8] = s_tdata;
		end else if (base_pos >= ffd_pkg::POS_BATTERY && base_pos < ffd_pkg::POS_FAULT) begin
			nxt_batt[{lane, 3'b000} +: 8] = s_tdata;
		end else if (base_pos == ffd_pkg::POS_FAULT) begin
			nxt_fault = s_tdata;
		end
	end

	// Result of the checksum beat; zero the data fields on any failure.
	always_comb begin
		res_d.status = nxt_fail;
		if (nxt_fail == ffd_pkg::ST_OK) begin
			res_d.left_distance_bits  = base_left;
			res_d.right_distance_bits = base_right;
			res_d.battery_bits        = base_batt;
			res_d.fault_value         = base_fault;
		end else begin
			res_d.left_distance_bits  = '0;
			res_d.right_distance_bits = '0;
			res_d.battery_bits        = '0;
			res_d.fault_value         = '0;
		end
	end

	// Frame tracker: advance on every accepted beat inside a frame, drop the rest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			in_frame_q <= 1'b0;
			sum_q      <= '0;
			fail_q     <= ffd_pkg::ST_OK;
			left_q     <= '0;
			right_q    <= '0;
			batt_q     <= '0;
			fault_q    <= '0;
		end else if (in_acc && base_in_frame) begin
			if (is_last) begin
				pos_q      <= '0;
				in_frame_q <= 1'b0;
			end else begin
				pos_q      <= base_pos + 1'b1;
				in_frame_q <= 1'b1;
				sum_q      <= base_sum + s_tdata;
				fail_q     <= nxt_fail;
				left_q     <= nxt_left;
				right_q    <= nxt_right;
				batt_q     <= nxt_batt;
				fault_q    <= nxt_fault;
			end
		end
	end

	// Result register: load on the checksum beat, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_acc && base_in_frame && is_last) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && base_in_frame && is_last)
			res_q <= res_d;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {{(ffd_pkg::RES_TDATA_W - ffd_pkg::RES_BITS){1'b0}}, res_q};

	// A failed frame never carries captured data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ffd_pkg::ST_OK) |->
		(res_q.left_distance_bits == '0 && res_q.right_distance_bits == '0 &&
		 res_q.battery_bits == '0 && res_q.fault_value == '0))
		else $error("failed frame result carries data");

	// The checksum beat of an open frame always produces a result.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && base_in_frame && is_last) |=> res_valid_q)
		else $error("frame end without result");

	// Position stays inside the frame.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("byte position beyond frame end");

	// Outside a frame the position is parked at zero.
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (pos_q == '0))
		else $error("byte position not cleared outside a frame");

	// A beat outside a frame without start leaves the tracker untouched.
	a_drop_stray: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !s_tuser && !in_frame_q) |=> (!in_frame_q && pos_q == '0))
		else $error("stray beat opened a frame");

endmodule
